// ----- rtl/arm64_adds_subs_executor_defines.svh -----
// ----------------------------------------------------------------------------
// arm64_adds_subs_executor_defines
// Assertion macros shared by the checker of the executor.
// ----------------------------------------------------------------------------
`ifndef ARM64_ADDS_SUBS_EXECUTOR_DEFINES_SVH
`define ARM64_ADDS_SUBS_EXECUTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A64AS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("executor check failed");

// The consequent must hold in the cycle after the antecedent.
`define A64AS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("executor check failed");

`endif

// ----- rtl/a64as_pkg.sv -----
// ----------------------------------------------------------------------------
// a64as_pkg
// Types, opcodes and status codes of the A64 add/subtract executor.
// ----------------------------------------------------------------------------
package a64as_pkg;

    localparam int XLEN      = 64;
    localparam int IWIDTH    = 32;
    localparam int NUM_REGS  = 32;
    localparam int RIDX_W    = 5;

    localparam logic [10:0] OPC_ADDS_IMM = 11'h588;
    localparam logic [10:0] OPC_ADDS_REG = 11'h558;
    localparam logic [10:0] OPC_SUBS_IMM = 11'h788;
    localparam logic [10:0] OPC_SUBS_REG = 11'h758;
    localparam logic [10:0] OPC_HLT      = 11'h6A2;
    localparam logic [4:0]  REG_ZR       = 5'h1F;

    localparam logic [1:0] STATUS_EXEC = 2'd0;
    localparam logic [1:0] STATUS_SKIP = 2'd1;
    localparam logic [1:0] STATUS_HALT = 2'd2;

    typedef logic [XLEN-1:0]   xword_t;
    typedef logic [IWIDTH-1:0] iword_t;
    typedef logic [RIDX_W-1:0] ridx_t;

    typedef struct packed {
        xword_t     next_pc;
        logic [1:0] status;
        logic       reg_we;
        ridx_t      widx;
        xword_t     wval;
        logic       z;
        logic       n;
        logic       halt_set;
    } exec_result_t;

endpackage

// ----- rtl/a64as_instr_if.sv -----
// ----------------------------------------------------------------------------
// a64as_instr_if
// Instruction channel: valid/ready handshake carrying one instruction word.
// ----------------------------------------------------------------------------
interface a64as_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink (input valid, input instr_word, output ready);
endinterface

// ----- rtl/a64as_result_if.sv -----
// ----------------------------------------------------------------------------
// a64as_result_if
// Result channel: valid/ready handshake carrying one execution result.
// ----------------------------------------------------------------------------
interface a64as_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_pc;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        zero_flag;
    logic        negative_flag;

    modport source (
        output valid, output next_pc, output status, output reg_written,
        output write_index, output write_value, output zero_flag,
        output negative_flag, input ready
    );
    modport sink (
        input valid, input next_pc, input status, input reg_written,
        input write_index, input write_value, input zero_flag,
        input negative_flag, output ready
    );
endinterface

// ----- rtl/a64as_regfile.sv -----
// ----------------------------------------------------------------------------
// a64as_regfile
// 32 x 64 register file in a synchronous memory with two read ports and one
// write port, per-entry valid bits for the all-zero reset, and forwarding of
// the most recent write.
// ----------------------------------------------------------------------------
module a64as_regfile (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  a64as_pkg::ridx_t   rd_addr_a,
    input  a64as_pkg::ridx_t   rd_addr_b,
    output a64as_pkg::xword_t  rd_data_a,
    output a64as_pkg::xword_t  rd_data_b,
    input  logic               wr_en,
    input  a64as_pkg::ridx_t   wr_addr,
    input  a64as_pkg::xword_t  wr_data
);
    import a64as_pkg::*;

    xword_t              mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;

    xword_t raw_a_reg;
    xword_t raw_b_reg;
    logic   hit_a_reg;
    logic   hit_b_reg;
    ridx_t  addr_a_reg;
    ridx_t  addr_b_reg;

    logic   fwd_vld_reg;
    ridx_t  fwd_addr_reg;
    xword_t fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_a_reg  <= mem_reg[rd_addr_a];
            raw_b_reg  <= mem_reg[rd_addr_b];
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                fwd_vld_reg      <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= vld_reg[rd_addr_a];
                hit_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // A write at the same edge as the read is not yet in the memory output,
    // so the latest write overrides the stored value.
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == addr_a_reg))
        begin
            rd_data_a = fwd_data_reg;
        end
        else if (hit_a_reg)
        begin
            rd_data_a = raw_a_reg;
        end
        else
        begin
            rd_data_a = '0;
        end

        if (fwd_vld_reg && (fwd_addr_reg == addr_b_reg))
        begin
            rd_data_b = fwd_data_reg;
        end
        else if (hit_b_reg)
        begin
            rd_data_b = raw_b_reg;
        end
        else
        begin
            rd_data_b = '0;
        end
    end

endmodule

// ----- rtl/a64as_alu.sv -----
// ----------------------------------------------------------------------------
// a64as_alu
// Decode and execute of ADDS, SUBS, CMP and HLT for one instruction word.
// ----------------------------------------------------------------------------
module a64as_alu (
    input  a64as_pkg::iword_t       instr,
    input  a64as_pkg::xword_t       rn_val,
    input  a64as_pkg::xword_t       rm_val,
    input  a64as_pkg::xword_t       pc,
    input  logic                    z_in,
    input  logic                    n_in,
    input  logic                    halted,
    output a64as_pkg::exec_result_t res
);
    import a64as_pkg::*;

    logic [10:0] top11;
    logic [8:0]  top9;
    ridx_t       rd;
    xword_t      imm;
    xword_t      operand;
    xword_t      sum;
    logic        is_add;
    logic        is_sub;

    assign top11 = instr[31:21];
    assign top9  = instr[31:23];
    assign rd    = instr[4:0];
    assign imm   = instr[22] ? {40'd0, instr[21:10], 12'd0} : {52'd0, instr[21:10]};

    always_comb
    begin
        is_add  = 1'b0;
        is_sub  = 1'b0;
        operand = '0;
        if (top9 == OPC_ADDS_IMM[10:2])
        begin
            is_add  = 1'b1;
            operand = imm;
        end
        else if (top9 == OPC_SUBS_IMM[10:2])
        begin
            is_sub  = 1'b1;
            operand = imm;
        end
        else if (top11 == OPC_ADDS_REG)
        begin
            is_add  = 1'b1;
            operand = rm_val;
        end
        else if (top11 == OPC_SUBS_REG)
        begin
            is_sub  = 1'b1;
            operand = rm_val;
        end
    end

    assign sum = is_add ? (rn_val + operand) : (rn_val - operand);

    always_comb
    begin
        res.next_pc  = pc;
        res.status   = STATUS_HALT;
        res.reg_we   = 1'b0;
        res.widx     = '0;
        res.wval     = '0;
        res.z        = z_in;
        res.n        = n_in;
        res.halt_set = 1'b0;
        if (halted)
        begin
            res.status = STATUS_HALT;
        end
        else if (top11 == OPC_HLT)
        begin
            res.halt_set = 1'b1;
        end
        else
        begin
            res.next_pc = pc + 64'd4;
            if (is_add || is_sub)
            begin
                res.status = STATUS_EXEC;
                res.z      = (sum == '0);
                res.n      = sum[XLEN-1];
                if (is_add || (rd != REG_ZR))
                begin
                    res.reg_we = 1'b1;
                    res.widx   = rd;
                    res.wval   = sum;
                end
            end
            else
            begin
                res.status = STATUS_SKIP;
            end
        end
    end

endmodule

// ----- rtl/arm64_adds_subs_executor.sv -----
// ----------------------------------------------------------------------------
// arm64_adds_subs_executor
// Executes ADDS/SUBS/CMP/HLT on a 32 x 64 register file with PC and Z/N flags.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one instruction word per transaction; the out_ch
// channel returns one result per instruction: next PC, status, the register
// write and the flags. The configuration port loads the PC with cfg_wr_data
// when cfg_wr_en is high; the user must write it only while no instruction is
// in flight, as the block does not enforce this. The instruction and its operand
// reads are registered in the execute stage, the result in the output register.
// Throughput is one instruction per cycle while out_ch.ready stays high: the
// register file is read in the accept cycle and written when the instruction
// leaves execute; the latest write is forwarded to the following instruction.
// Reset clears the PC, the flags, the halt state and the register file valid
// bits, so every register reads as zero until written; no clearing pass is run.
// When the receiver stalls, the result is held in the output register, one more
// instruction waits in the execute stage, and then in_ch.ready falls.
// After HLT every further instruction returns status halted.
// ----------------------------------------------------------------------------
module arm64_adds_subs_executor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    a64as_instr_if.sink           in_ch,
    a64as_result_if.source        out_ch
);
    import a64as_pkg::*;

    logic         in_fire;
    logic         s1_fire;
    logic         s1_valid_reg;
    iword_t       s1_instr_reg;
    xword_t       pc_reg;
    logic         z_reg;
    logic         n_reg;
    logic         halted_reg;
    logic         out_valid_reg;
    exec_result_t out_reg;
    xword_t       rn_val;
    xword_t       rm_val;
    exec_result_t ex;

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    a64as_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_addr_a (in_ch.instr_word[9:5]),
        .rd_addr_b (in_ch.instr_word[20:16]),
        .rd_data_a (rn_val),
        .rd_data_b (rm_val),
        .wr_en     (s1_fire && ex.reg_we),
        .wr_addr   (ex.widx),
        .wr_data   (ex.wval)
    );

    a64as_alu u_alu (
        .instr  (s1_instr_reg),
        .rn_val (rn_val),
        .rm_val (rm_val),
        .pc     (pc_reg),
        .z_in   (z_reg),
        .n_in   (n_reg),
        .halted (halted_reg),
        .res    (ex)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            z_reg         <= 1'b0;
            n_reg         <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
            else if (s1_fire)
            begin
                pc_reg <= ex.next_pc;
            end
            if (s1_fire)
            begin
                z_reg <= ex.z;
                n_reg <= ex.n;
                if (ex.halt_set)
                begin
                    halted_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= in_ch.instr_word;
        end
        if (s1_fire)
        begin
            out_reg <= ex;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.next_pc       = out_reg.next_pc;
    assign out_ch.status        = out_reg.status;
    assign out_ch.reg_written   = out_reg.reg_we;
    assign out_ch.write_index   = out_reg.widx;
    assign out_ch.write_value   = out_reg.wval;
    assign out_ch.zero_flag     = out_reg.z;
    assign out_ch.negative_flag = out_reg.n;

endmodule

// ----- rtl/a64as_checker.sv -----
// ----------------------------------------------------------------------------
// a64as_checker
// Port-level checks of the executor's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm64_adds_subs_executor_defines.svh"

module a64as_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        reg_written,
    input logic [4:0]  write_index,
    input logic [63:0] write_value,
    input logic        zero_flag,
    input logic        negative_flag
);
    import a64as_pkg::*;

    // A result that is not taken stays on the channel.
    `A64AS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid)

    // Flags of a written result follow the value written.
    `A64AS_ASSERT_NOW(a_flags_match, out_valid && reg_written,
        (zero_flag == (write_value == 64'd0)) && (negative_flag == write_value[63]))

    // Only executed instructions write a register; otherwise the write fields are zero.
    `A64AS_ASSERT_NOW(a_no_write_fields, out_valid && !reg_written,
        (write_index == 5'd0) && (write_value == 64'd0))

    // After a delivered halted result, a result that follows at once is halted too.
    `A64AS_ASSERT_NEXT(a_halt_sticky, out_valid && out_ready && (status == STATUS_HALT),
        !out_valid || ((status == STATUS_HALT) && !reg_written))

endmodule

bind arm64_adds_subs_executor a64as_checker u_a64as_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_ch.status),
    .reg_written   (out_ch.reg_written),
    .write_index   (out_ch.write_index),
    .write_value   (out_ch.write_value),
    .zero_flag     (out_ch.zero_flag),
    .negative_flag (out_ch.negative_flag)
);

// ----- test/arm64_adds_subs_executor_checker.sv -----
// ----------------------------------------------------------------------------
// arm64_adds_subs_executor_checker
// Watches both channels and the configuration port of the executor. It keeps
// its own copy of the register file, PC, flags and halt state. It predicts
// every retired instruction and compares each result transaction against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm64_adds_subs_executor_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  a64as_pkg::xword_t  cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  a64as_pkg::iword_t  in_word,
    input  logic               out_valid,
    input  logic               out_ready,
    input  a64as_pkg::xword_t  out_next_pc,
    input  logic [1:0]         out_status,
    input  logic               out_reg_written,
    input  a64as_pkg::ridx_t   out_write_index,
    input  a64as_pkg::xword_t  out_write_value,
    input  logic               out_zero_flag,
    input  logic               out_negative_flag,
    output int                 mismatch_count,
    output int                 pending_count
);
    import a64as_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        xword_t     next_pc;
        logic [1:0] status;
        logic       reg_written;
        ridx_t      write_index;
        xword_t     write_value;
        logic       zero_flag;
        logic       negative_flag;
    } retire_t;

    xword_t  arch_regs [NUM_REGS];
    xword_t  arch_pc;
    logic    flag_z;
    logic    flag_n;
    logic    is_halted;
    retire_t expected_retires [$];

    task automatic report(input string what, input xword_t got, input xword_t want);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic retire_t execute_instr(input iword_t w);
        retire_t r;
        ridx_t   rd;
        ridx_t   rn;
        ridx_t   rm;
        xword_t  imm;
        xword_t  operand;
        xword_t  sum;
        logic    is_add;
        logic    is_sub;
        r = '0;
        rd = w[4:0];
        rn = w[9:5];
        rm = w[20:16];
        imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        is_add = 1'b0;
        is_sub = 1'b0;
        operand = '0;
        if (is_halted)
        begin
            r.status = STATUS_HALT;
        end
        else if (w[31:21] == OPC_HLT)
        begin
            is_halted = 1'b1;
            r.status = STATUS_HALT;
        end
        else
        begin
            r.status = STATUS_EXEC;
            if (w[31:23] == OPC_ADDS_IMM[10:2])
            begin
                is_add = 1'b1;
                operand = imm;
            end
            else if (w[31:23] == OPC_SUBS_IMM[10:2])
            begin
                is_sub = 1'b1;
                operand = imm;
            end
            else if (w[31:21] == OPC_ADDS_REG)
            begin
                is_add = 1'b1;
                operand = arch_regs[rm];
            end
            else if (w[31:21] == OPC_SUBS_REG)
            begin
                is_sub = 1'b1;
                operand = arch_regs[rm];
            end
            else
            begin
                r.status = STATUS_SKIP;
            end
            if (is_add || is_sub)
            begin
                sum = is_add ? arch_regs[rn] + operand : arch_regs[rn] - operand;
                flag_z = (sum == '0);
                flag_n = sum[XLEN-1];
                // A subtract into the zero register is a compare: flags only.
                if (is_add || rd != REG_ZR)
                begin
                    arch_regs[rd] = sum;
                    r.reg_written = 1'b1;
                    r.write_index = rd;
                    r.write_value = sum;
                end
            end
            arch_pc = arch_pc + 64'd4;
        end
        r.next_pc = arch_pc;
        r.zero_flag = flag_z;
        r.negative_flag = flag_n;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        retire_t want;
        if (!rst_n)
        begin
            foreach (arch_regs[i])
            begin
                arch_regs[i] = '0;
            end
            arch_pc = '0;
            flag_z = 1'b0;
            flag_n = 1'b0;
            is_halted = 1'b0;
            expected_retires.delete();
            mismatch_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                arch_pc = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                expected_retires.push_back(execute_instr(in_word));
            end
            if (out_valid && out_ready)
            begin
                if (expected_retires.size() == 0)
                begin
                    report("result transaction with no instruction pending",
                           out_next_pc, '0);
                end
                else
                begin
                    want = expected_retires.pop_front();
                    if (out_next_pc !== want.next_pc)
                    begin
                        report("next_pc", out_next_pc, want.next_pc);
                    end
                    if (out_status !== want.status)
                    begin
                        report("status", out_status, want.status);
                    end
                    if (out_reg_written !== want.reg_written)
                    begin
                        report("reg_written", out_reg_written, want.reg_written);
                    end
                    if (out_write_index !== want.write_index)
                    begin
                        report("write_index", out_write_index, want.write_index);
                    end
                    if (out_write_value !== want.write_value)
                    begin
                        report("write_value", out_write_value, want.write_value);
                    end
                    if (out_zero_flag !== want.zero_flag)
                    begin
                        report("zero_flag", out_zero_flag, want.zero_flag);
                    end
                    if (out_negative_flag !== want.negative_flag)
                    begin
                        report("negative_flag", out_negative_flag, want.negative_flag);
                    end
                end
            end
            pending_count <= expected_retires.size();
        end
    end

endmodule

// ----- test/tb_arm64_adds_subs_executor.sv -----
// ----------------------------------------------------------------------------
// tb_arm64_adds_subs_executor
// Drives instruction words into the executor in random bursts while the
// result side stalls on its own pattern. A directed program covers the
// immediate and register forms, compares, register thirty-one, wrap-around
// and unknown words. Random programs run under several start PCs, and a
// final HLT is followed by ignored words. The checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arm64_adds_subs_executor;
    import a64as_pkg::*;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 5;
    localparam int DRAIN_CYCLES    = 8;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [63:0] cfg_wr_data;
    int mismatch_count;
    int pending_count;
    int burst_left;
    int unsigned rx_cycle;
    logic [1:0] rx_mode;
    xword_t phase_pc [NUM_PHASES];

    a64as_instr_if  in_ch();
    a64as_result_if out_ch();

    arm64_adds_subs_executor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    arm64_adds_subs_executor_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_ch.valid),
        .in_ready          (in_ch.ready),
        .in_word           (in_ch.instr_word),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_next_pc       (out_ch.next_pc),
        .out_status        (out_ch.status),
        .out_reg_written   (out_ch.reg_written),
        .out_write_index   (out_ch.write_index),
        .out_write_value   (out_ch.write_value),
        .out_zero_flag     (out_ch.zero_flag),
        .out_negative_flag (out_ch.negative_flag),
        .mismatch_count    (mismatch_count),
        .pending_count     (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver switches between always ready, random stalls, a fixed
    // stall pattern and long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_cycle = 0;
            rx_mode <= 2'd0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 97 == 0)
            begin
                rx_mode <= 2'($urandom_range(0, 3));
            end
            case (rx_mode)
                2'd0: out_ch.ready <= 1'b1;
                2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
                2'd2: out_ch.ready <= (rx_cycle % 5) != 0;
                default: out_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic iword_t enc_imm(input logic sub, input logic sh,
                                       input logic [11:0] imm12, input ridx_t rn,
                                       input ridx_t rd);
        logic [10:0] opc;
        opc = sub ? OPC_SUBS_IMM : OPC_ADDS_IMM;
        return {opc[10:2], sh, imm12, rn, rd};
    endfunction

    function automatic iword_t enc_reg(input logic sub, input ridx_t rm,
                                       input logic [5:0] imm6, input ridx_t rn,
                                       input ridx_t rd);
        return {(sub ? OPC_SUBS_REG : OPC_ADDS_REG), rm, imm6, rn, rd};
    endfunction

    function automatic ridx_t pick_reg();
        if ($urandom_range(0, 5) == 0)
        begin
            return REG_ZR;
        end
        return ridx_t'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31));
    endfunction

    function automatic iword_t random_instr();
        int unsigned pick;
        iword_t w;
        ridx_t rn;
        ridx_t rm;
        logic sub;
        pick = $urandom_range(0, 99);
        rn = pick_reg();
        rm = pick_reg();
        sub = pick >= 22 && pick < 44 || pick >= 64;
        if (pick < 44)
        begin
            w = enc_imm(sub, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                        rn, pick_reg());
        end
        else if (pick < 84)
        begin
            if (sub && $urandom_range(0, 7) == 0)
            begin
                rm = rn;
            end
            w = enc_reg(sub, rm, 6'($urandom_range(0, 63)), rn, pick_reg());
        end
        else if (pick < 94)
        begin
            w = $urandom();
        end
        else
        begin
            w = $urandom_range(0, 1) ? enc_reg(1'($urandom_range(0, 1)), rm, 6'($urandom()),
                                               rn, pick_reg())
                                     : enc_imm(1'($urandom_range(0, 1)), 1'($urandom()),
                                               12'($urandom()), rn, pick_reg());
            w[21 + $urandom_range(0, 10)] ^= 1'b1;
        end
        // The halt is kept for the end of the run.
        if (w[31:21] == OPC_HLT)
        begin
            w[21] = ~w[21];
        end
        return w;
    endfunction

    task automatic send_instr(input iword_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid <= 1'b1;
        in_ch.instr_word <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_start_pc(input xword_t pc);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.instr_word <= '0;
        burst_left = 0;
        phase_pc[0] = '0;
        phase_pc[1] = '1;
        phase_pc[2] = 64'h7FFF_FFFF_FFFF_FFF0;
        phase_pc[3] = {$urandom(), $urandom()};
        phase_pc[4] = {$urandom(), $urandom()};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed program starts close to the top of the address space
        // so that the PC wraps within it.
        load_start_pc(64'hFFFF_FFFF_FFFF_FFEC);
        send_instr(enc_imm(1'b0, 1'b0, 12'hFFF, 5'd0, 5'd1));
        send_instr(enc_imm(1'b0, 1'b1, 12'hFFF, 5'd1, 5'd2));
        send_instr(enc_imm(1'b0, 1'b0, 12'h000, REG_ZR, 5'd3));
        send_instr(enc_imm(1'b1, 1'b0, 12'h001, 5'd0, 5'd4));
        send_instr(enc_imm(1'b0, 1'b0, 12'h001, 5'd4, REG_ZR));
        send_instr(enc_reg(1'b0, 5'd4, 6'h3F, 5'd4, 5'd5));
        send_instr(enc_reg(1'b1, 5'd2, 6'h00, 5'd2, 5'd6));
        send_instr(enc_reg(1'b1, 5'd2, 6'h15, 5'd1, REG_ZR));
        send_instr(enc_imm(1'b1, 1'b0, 12'hFFF, 5'd1, REG_ZR));
        send_instr(enc_imm(1'b1, 1'b1, 12'h800, 5'd2, 5'd7));
        send_instr(enc_reg(1'b0, REG_ZR, 6'h2A, 5'd5, 5'd8));
        send_instr(enc_reg(1'b0, REG_ZR, 6'h00, REG_ZR, REG_ZR));
        send_instr(enc_reg(1'b1, 5'd4, 6'h3F, 5'd0, 5'd9));
        send_instr(enc_imm(1'b0, 1'b1, 12'hFFF, 5'd9, 5'd10));
        send_instr(32'h0000_0000);
        send_instr(32'hFFFF_FFFF);
        send_instr({OPC_HLT ^ 11'h001, 21'h1F_FFFF});
        send_instr({OPC_ADDS_REG | 11'h001, 21'h0A_5A5A});
        send_instr({OPC_SUBS_REG ^ 11'h400, 21'h15_A5A5});

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_start_pc(phase_pc[p]);
            repeat (ITEMS_PER_PHASE) send_instr(random_instr());
        end

        // Halt with random low bits; everything after it is ignored.
        send_instr({OPC_HLT, 21'($urandom())});
        repeat (4) send_instr($urandom());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/a64as_pkg.sv
rtl/a64as_instr_if.sv
rtl/a64as_result_if.sv
rtl/a64as_regfile.sv
rtl/a64as_alu.sv
rtl/arm64_adds_subs_executor.sv
rtl/a64as_checker.sv
test/arm64_adds_subs_executor_checker.sv
test/tb_arm64_adds_subs_executor.sv
